FILE: design/assert_macros.svh
// Assertion macros shared by the heap manager RTL.
// Each macro is clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BFHM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("heap manager assertion failed");
`define BFHM_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("heap manager forbidden condition");
`else
`define BFHM_ASSERT(label, prop)
`define BFHM_NEVER(label, expr)
`endif
`endif

FILE: design/bfhm_pkg.sv
// Package of the best-fit heap manager: arena constants, codes, FSM types.
// Used by bfhm_dp, bfhm_ctrl and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package bfhm_pkg;

    // Arena geometry.
    localparam int ARENA_UNITS     = 4096;
    localparam int UNIT_BYTES      = 8;
    localparam int HDR_BYTES       = 8;
    localparam int MIN_SPLIT_BYTES = 16;
    localparam int LAST_UNIT       = ARENA_UNITS - 1;
    localparam int AW              = $clog2(ARENA_UNITS);
    localparam int SW              = AW + 1;
    localparam int MIN_SPLIT_UNITS = (MIN_SPLIT_BYTES + UNIT_BYTES - 1) / UNIT_BYTES;

    // Word field widths.
    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 16;
    localparam int OFF_W    = 15;
    localparam int STATUS_W = 2;
    localparam int NEED_W   =
        $clog2((65535 + HDR_BYTES + UNIT_BYTES - 1) / UNIT_BYTES + 1);

    typedef logic [AW-1:0] t_unit;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESIZE = 2'd2;

    // Answer codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FIT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_GROW    = 2'd3;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_DEC, S_HEAD, S_WSTART, S_WALK, S_WDEC, S_TAKE,
        S_SPLIT_DEC, S_SPLIT1, S_SPLIT2, S_SPLIT3, S_MFREE, S_ARD, S_MA, S_MB,
        S_ANS_OK, S_ANS_FAIL, S_ANS_IGN, S_ANS_GROW, S_RESP
    } t_state;

    // Datapath commands, one per cycle.
    typedef enum logic [4:0] {
        OP_NONE, OP_CLEAR, OP_LATCH, OP_HEAD_RD, OP_WALK_START, OP_WALK_STEP,
        OP_TAKE, OP_SPLIT1, OP_SPLIT2, OP_SPLIT3, OP_MFREE, OP_A_RD, OP_A_STEP,
        OP_B_STEP, OP_ANS_OK, OP_ANS_FAIL, OP_ANS_IGN, OP_ANS_GROW
    } t_op;

    // Datapath status flags seen by the controller.
    typedef struct packed {
        logic clr_last;
        logic alloc_path;
        logic size_zero;
        logic ign_direct;
        logic head_cont;
        logic walk_cont;
        logic best_valid;
        logic found;
        logic free_or_zero;
        logic rs_eq;
        logic rs_gt;
        logic need_split;
        logic merge_cont;
        logic split_done;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: design/bfhm_dp.sv
// Datapath of the heap manager: header memories, walk registers, answers.
// Depends on bfhm_pkg and assert_macros.svh; driven by bfhm_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bfhm_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bfhm_pkg::t_op                      i_op,
    input  logic [bfhm_pkg::KIND_W-1:0]        i_kind,
    input  logic [bfhm_pkg::SIZE_W-1:0]        i_size_bytes,
    input  logic [bfhm_pkg::OFF_W-1:0]         i_payload_offset,
    output bfhm_pkg::t_dp_status               o_st,
    output logic [bfhm_pkg::STATUS_W-1:0]      o_status,
    output logic [bfhm_pkg::OFF_W-1:0]         o_result_offset,
    output logic [bfhm_pkg::OFF_W-1:0]         o_usable_size
);
    import bfhm_pkg::*;

    // Header store: next link, prev link and taken bit per unit.
    t_unit r_next_mem [ARENA_UNITS];
    t_unit r_prev_mem [ARENA_UNITS];
    logic  r_taken_mem [ARENA_UNITS];

    t_unit r_rd_next;
    t_unit r_rd_prev;
    logic  r_rd_taken;

    logic [KIND_W-1:0]   r_kind;
    logic [SIZE_W-1:0]   r_size;
    logic [OFF_W-1:0]    r_off;
    logic [NEED_W-1:0]   r_need;
    t_unit               r_clr;
    t_unit               r_cur;
    logic [SW-1:0]       r_steps;
    t_unit               r_best;
    t_unit               r_bestsz;
    logic                r_best_valid;
    logic                r_found;
    logic                r_split;
    t_unit               r_u;
    t_unit               r_bs;
    t_unit               r_p;
    t_unit               r_a;
    t_unit               r_b;
    logic [STATUS_W-1:0] r_status;
    logic [OFF_W-1:0]    r_res_off;
    logic [OFF_W-1:0]    r_res_usable;

    logic          alloc_path;
    logic          off_ok;
    logic [OFF_W-1:0] uoff;
    logic          hit;
    t_unit         bs_cur;
    logic          cand;
    logic          head_cont;
    logic          merge_cont;
    logic          link_need;
    logic [31:0]   usable32;
    t_unit         split_t;
    t_unit         split_n;
    t_unit         clr_next;
    t_unit         clr_prev;
    logic          clr_taken;

    logic  rd_en;
    t_unit raddr;
    logic  next_we;
    t_unit next_wa;
    t_unit next_wd;
    logic  prev_we;
    t_unit prev_wa;
    t_unit prev_wd;
    logic  taken_we;
    t_unit taken_wa;
    logic  taken_wd;

    // Request decode and per-step arithmetic.
    always_comb begin
        alloc_path = (r_kind == KIND_ALLOC) ||
                     ((r_kind == KIND_RESIZE) && (r_off == '0));
        off_ok     = (32'(r_off) >= HDR_BYTES) &&
                     (((32'(r_off) - HDR_BYTES) % UNIT_BYTES) == 0);
        uoff       = OFF_W'((32'(r_off) - HDR_BYTES) / UNIT_BYTES);
        hit        = !alloc_path && (32'(r_cur) == 32'(uoff));
        bs_cur     = (r_rd_next > r_cur) ? t_unit'(r_rd_next - r_cur) : '0;
        cand       = !r_rd_taken && (32'(r_need) <= 32'(bs_cur)) &&
                     (!r_best_valid || (bs_cur < r_bestsz));
        head_cont  = r_rd_next < t_unit'(LAST_UNIT);
        merge_cont = !r_rd_taken && (r_steps < SW'(ARENA_UNITS));
        link_need  = (r_a != r_p) || (r_rd_prev != r_p);
        usable32   = 32'(r_bs) * UNIT_BYTES - HDR_BYTES;
        split_t    = t_unit'(32'(r_u) + 32'(r_need));
        split_n    = t_unit'(32'(r_u) + 32'(r_bs));
        clr_next   = (r_clr == '0) ? t_unit'(1) :
                     (r_clr == t_unit'(1)) ? t_unit'(LAST_UNIT) : '0;
        clr_prev   = (r_clr == t_unit'(LAST_UNIT)) ? t_unit'(1) : '0;
        clr_taken  = (r_clr == '0) || (r_clr == t_unit'(LAST_UNIT));
    end

    // Status flags for the controller.
    always_comb begin
        o_st.clr_last     = (r_clr == t_unit'(LAST_UNIT));
        o_st.alloc_path   = alloc_path;
        o_st.size_zero    = (r_size == '0);
        o_st.ign_direct   = !alloc_path &&
                            (!(r_kind inside {KIND_FREE, KIND_RESIZE}) || !off_ok);
        o_st.head_cont    = head_cont;
        o_st.walk_cont    = !hit && head_cont &&
                            ((r_steps + SW'(1)) < SW'(ARENA_UNITS));
        o_st.best_valid   = r_best_valid;
        o_st.found        = r_found;
        o_st.free_or_zero = (r_kind == KIND_FREE) || (r_size == '0);
        o_st.rs_eq        = (32'(r_size) == usable32);
        o_st.rs_gt        = (32'(r_size) > usable32);
        o_st.need_split   = (32'(r_bs) > 32'(r_need)) &&
                            ((32'(r_bs) - 32'(r_need)) >= MIN_SPLIT_UNITS);
        o_st.merge_cont   = merge_cont;
        o_st.split_done   = r_split;
    end

    // Memory port control per command.
    always_comb begin
        rd_en    = 1'b0;
        raddr    = '0;
        next_we  = 1'b0;
        next_wa  = '0;
        next_wd  = '0;
        prev_we  = 1'b0;
        prev_wa  = '0;
        prev_wd  = '0;
        taken_we = 1'b0;
        taken_wa = '0;
        taken_wd = 1'b0;
        case (i_op)
            OP_CLEAR: begin
                next_we  = 1'b1;
                next_wa  = r_clr;
                next_wd  = clr_next;
                prev_we  = 1'b1;
                prev_wa  = r_clr;
                prev_wd  = clr_prev;
                taken_we = 1'b1;
                taken_wa = r_clr;
                taken_wd = clr_taken;
            end
            OP_HEAD_RD: begin
                rd_en = 1'b1;
            end
            OP_WALK_START, OP_WALK_STEP: begin
                rd_en = 1'b1;
                raddr = r_rd_next;
            end
            OP_TAKE: begin
                taken_we = 1'b1;
                taken_wa = r_best;
                taken_wd = 1'b1;
            end
            OP_SPLIT1: begin
                next_we  = 1'b1;
                next_wa  = split_t;
                next_wd  = split_n;
                prev_we  = 1'b1;
                prev_wa  = split_t;
                prev_wd  = r_u;
                taken_we = 1'b1;
                taken_wa = split_t;
            end
            OP_SPLIT2: begin
                prev_we = 1'b1;
                prev_wa = split_n;
                prev_wd = split_t;
            end
            OP_SPLIT3: begin
                next_we = 1'b1;
                next_wa = r_u;
                next_wd = split_t;
            end
            OP_MFREE: begin
                taken_we = 1'b1;
                taken_wa = r_p;
            end
            OP_A_RD: begin
                rd_en = 1'b1;
                raddr = r_p;
            end
            OP_A_STEP: begin
                rd_en = 1'b1;
                raddr = merge_cont ? r_rd_prev : r_p;
            end
            OP_B_STEP: begin
                if (merge_cont) begin
                    rd_en = 1'b1;
                    raddr = r_rd_next;
                end else if (link_need) begin
                    next_we = 1'b1;
                    next_wa = r_a;
                    next_wd = r_b;
                    prev_we = 1'b1;
                    prev_wa = r_b;
                    prev_wd = r_a;
                end
            end
            default: begin
            end
        endcase
    end

    // Header memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        if (taken_we) begin
            r_taken_mem[taken_wa] <= taken_wd;
        end
        if (rd_en) begin
            r_rd_next  <= r_next_mem[raddr];
            r_rd_prev  <= r_prev_mem[raddr];
            r_rd_taken <= r_taken_mem[raddr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr        <= '0;
            r_best_valid <= 1'b0;
            r_found      <= 1'b0;
            r_split      <= 1'b0;
        end else begin
            case (i_op)
                OP_CLEAR: begin
                    r_clr <= r_clr + t_unit'(1);
                end
                OP_LATCH: begin
                    r_best_valid <= 1'b0;
                    r_found      <= 1'b0;
                    r_split      <= 1'b0;
                end
                OP_WALK_STEP: begin
                    if (alloc_path && cand) begin
                        r_best_valid <= 1'b1;
                    end
                    if (hit) begin
                        r_found <= r_rd_taken;
                    end
                end
                OP_SPLIT3: begin
                    r_split <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LATCH: begin
                r_kind <= i_kind;
                r_size <= i_size_bytes;
                r_off  <= i_payload_offset;
                r_need <= NEED_W'((32'(i_size_bytes) + HDR_BYTES + UNIT_BYTES - 1)
                                  / UNIT_BYTES);
            end
            OP_WALK_START: begin
                r_cur   <= r_rd_next;
                r_steps <= '0;
            end
            OP_WALK_STEP: begin
                if (alloc_path && cand) begin
                    r_best   <= r_cur;
                    r_bestsz <= bs_cur;
                end
                if (hit) begin
                    r_u  <= r_cur;
                    r_bs <= bs_cur;
                    r_p  <= r_cur;
                end
                r_cur   <= r_rd_next;
                r_steps <= r_steps + SW'(1);
            end
            OP_TAKE: begin
                r_u  <= r_best;
                r_bs <= r_bestsz;
            end
            OP_SPLIT3: begin
                r_p  <= split_t;
                r_bs <= t_unit'(r_need);
            end
            OP_MFREE: begin
                r_steps <= '0;
            end
            OP_A_STEP: begin
                if (merge_cont) begin
                    r_steps <= r_steps + SW'(1);
                end else begin
                    r_a     <= r_rd_next;
                    r_b     <= r_p;
                    r_steps <= '0;
                end
            end
            OP_B_STEP: begin
                if (merge_cont) begin
                    r_b     <= r_rd_next;
                    r_steps <= r_steps + SW'(1);
                end
            end
            OP_ANS_OK, OP_ANS_GROW: begin
                r_status     <= (i_op == OP_ANS_OK) ? ST_OK : ST_GROW;
                r_res_off    <= OFF_W'(32'(r_u) * UNIT_BYTES + HDR_BYTES);
                r_res_usable <= OFF_W'(usable32);
            end
            OP_ANS_FAIL, OP_ANS_IGN: begin
                r_status     <= (i_op == OP_ANS_FAIL) ? ST_NO_FIT : ST_IGNORED;
                r_res_off    <= '0;
                r_res_usable <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_status        = r_status;
    assign o_result_offset = r_res_off;
    assign o_usable_size   = r_res_usable;

    // A split point always lies above the start of the block being split.
    `BFHM_ASSERT(a_split_inside, (i_op == OP_SPLIT1) |-> (split_t > r_u))
    // The best candidate always fits the request.
    `BFHM_ASSERT(a_best_fits, r_best_valid |-> (32'(r_bestsz) >= 32'(r_need)))
    // The list walk never visits the closing guard.
    `BFHM_ASSERT(a_walk_range, (i_op == OP_WALK_STEP) |-> (r_cur < t_unit'(LAST_UNIT)))

endmodule
`default_nettype wire

FILE: design/bfhm_ctrl.sv
// Controller of the heap manager: sequences list walks, splits and merges.
// Depends on bfhm_pkg and assert_macros.svh; issues commands to bfhm_dp.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bfhm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  bfhm_pkg::t_dp_status  i_st,
    output bfhm_pkg::t_op         o_op,
    output logic                  o_busy,
    output logic                  o_valid
);
    import bfhm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) n_state = S_DEC;
            end
            S_DEC: begin
                if (i_st.ign_direct) n_state = S_ANS_IGN;
                else if (i_st.alloc_path && i_st.size_zero) n_state = S_ANS_FAIL;
                else n_state = S_HEAD;
            end
            S_HEAD:   n_state = S_WSTART;
            S_WSTART: n_state = i_st.head_cont ? S_WALK : S_WDEC;
            S_WALK:   n_state = i_st.walk_cont ? S_WALK : S_WDEC;
            S_WDEC: begin
                if (i_st.alloc_path) begin
                    n_state = i_st.best_valid ? S_TAKE : S_ANS_FAIL;
                end else if (!i_st.found) begin
                    n_state = S_ANS_IGN;
                end else if (i_st.free_or_zero) begin
                    n_state = S_MFREE;
                end else if (i_st.rs_eq) begin
                    n_state = S_ANS_OK;
                end else if (i_st.rs_gt) begin
                    n_state = S_ANS_GROW;
                end else begin
                    n_state = S_SPLIT_DEC;
                end
            end
            S_TAKE:      n_state = S_SPLIT_DEC;
            S_SPLIT_DEC: n_state = i_st.need_split ? S_SPLIT1 : S_ANS_OK;
            S_SPLIT1:    n_state = S_SPLIT2;
            S_SPLIT2:    n_state = S_SPLIT3;
            S_SPLIT3:    n_state = S_MFREE;
            S_MFREE:     n_state = S_ARD;
            S_ARD:       n_state = S_MA;
            S_MA:        n_state = i_st.merge_cont ? S_MA : S_MB;
            S_MB: begin
                if (!i_st.merge_cont) begin
                    n_state = i_st.split_done ? S_ANS_OK : S_ANS_IGN;
                end
            end
            S_ANS_OK, S_ANS_FAIL, S_ANS_IGN, S_ANS_GROW: n_state = S_RESP;
            S_RESP:  n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // Command and handshake outputs.
    always_comb begin
        o_op    = OP_NONE;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_INIT:     o_op = OP_CLEAR;
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) o_op = OP_LATCH;
            end
            S_HEAD:     o_op = OP_HEAD_RD;
            S_WSTART:   o_op = OP_WALK_START;
            S_WALK:     o_op = OP_WALK_STEP;
            S_TAKE:     o_op = OP_TAKE;
            S_SPLIT1:   o_op = OP_SPLIT1;
            S_SPLIT2:   o_op = OP_SPLIT2;
            S_SPLIT3:   o_op = OP_SPLIT3;
            S_MFREE:    o_op = OP_MFREE;
            S_ARD:      o_op = OP_A_RD;
            S_MA:       o_op = OP_A_STEP;
            S_MB:       o_op = OP_B_STEP;
            S_ANS_OK:   o_op = OP_ANS_OK;
            S_ANS_FAIL: o_op = OP_ANS_FAIL;
            S_ANS_IGN:  o_op = OP_ANS_IGN;
            S_ANS_GROW: o_op = OP_ANS_GROW;
            S_RESP:     o_valid = 1'b1;
            default:    o_op = OP_NONE;
        endcase
    end

    // Each answer is a single-cycle strobe.
    `BFHM_ASSERT(a_valid_pulse, o_valid |=> !o_valid)
    // An accepted request makes the block busy at once.
    `BFHM_ASSERT(a_accept_busy, (i_start && !o_busy) |=> o_busy)
    // After the answer the block is ready for the next request.
    `BFHM_ASSERT(a_resp_ready, o_valid |=> !o_busy)

endmodule
`default_nettype wire

FILE: design/best_fit_heap_manager.sv
// Top level of the best-fit heap manager: controller plus datapath.
// Depends on bfhm_pkg, bfhm_ctrl and bfhm_dp.
//
// Usage: raise start with kind, size_bytes and payload_offset while busy is
// low; the word is taken at that clock edge and busy rises. The answer word
// (status, result offset, usable size) appears for exactly one cycle with
// o_valid high, then busy drops in the following cycle. The receiver cannot
// stall the answer; it must sample it in the o_valid cycle.
// The request walks the block list from the arena head, one block per
// cycle through the registered read port of the header memories. An
// allocate then takes the chosen block. An allocate or a shrinking resize
// may split the block, rewriting the new block's header, the next block's
// prev link and the old block's next link; each merge walks the free
// headers back and then forward and joins the run into one block. A
// 4096-unit arena holds at most 2047 blocks.
// Reset: a clearing pass rewrites all 4096 header entries, one per cycle,
// and busy stays high until the pass is done.
`timescale 1ns / 1ps
`default_nettype none
module best_fit_heap_manager (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [bfhm_pkg::KIND_W-1:0]       i_kind,
    input  logic [bfhm_pkg::SIZE_W-1:0]       i_size_bytes,
    input  logic [bfhm_pkg::OFF_W-1:0]        i_payload_offset,
    output logic                              o_valid,
    output logic [bfhm_pkg::STATUS_W-1:0]     o_status,
    output logic [bfhm_pkg::OFF_W-1:0]        o_result_offset,
    output logic [bfhm_pkg::OFF_W-1:0]        o_usable_size
);
    import bfhm_pkg::*;

    t_op        op;
    t_dp_status st;

    // Sequencer.
    bfhm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_op    (op),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    // Header store and arithmetic.
    bfhm_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_kind           (i_kind),
        .i_size_bytes     (i_size_bytes),
        .i_payload_offset (i_payload_offset),
        .o_st             (st),
        .o_status         (o_status),
        .o_result_offset  (o_result_offset),
        .o_usable_size    (o_usable_size)
    );

endmodule
`default_nettype wire
